// File: design/dlp_pkg.sv
// Package: types and constants for the DAG longest-path block.
`timescale 1ns / 1ps
package dlp_pkg;
  localparam int NODES = 32;
  localparam int NODE_BITS = 5;
  localparam int EDGES = 256;
  localparam int EDGE_BITS = 8;
  localparam int LINK_BITS = 9;
  localparam int LENGTH_BITS = 16;
  localparam int DIST_BITS = 24;
  localparam int CNT_BITS = 6;
  localparam int PAIRS = NODES * NODES;
  localparam int PAIR_BITS = 10;
  localparam logic [LINK_BITS-1:0] NO_LINK = {LINK_BITS{1'b1}};
  localparam logic signed [DIST_BITS:0] DIST_MAX = (DIST_BITS+1)'((1 << (DIST_BITS-1)) - 1);

  typedef struct packed {
    logic [NODE_BITS-1:0]   from_node;
    logic [NODE_BITS-1:0]   to_node;
    logic [LENGTH_BITS-1:0] edge_length;
    logic                   last_edge;
  } edge_req_t;

  typedef struct packed {
    logic [NODE_BITS-1:0]   path_from;
    logic [NODE_BITS-1:0]   path_to;
    logic [LENGTH_BITS-1:0] path_length;
    logic                   last_in_path;
    logic                   path_empty;
  } path_res_t;
endpackage

// File: design/dag_longest_path.sv
// Top level: edge loader, depth-first ordering, relaxation and path output.
// Flow: a non-last request goes through the pair-table read, then the write; a repeated
// pair instead reads the stored weight, then compares and writes. A last request starts
// the walk and relax loops, whose length is set by their adjacency memory reads, then the
// path output; then the 1024 pair-table entries are cleared, one entry a cycle.
// A new request is taken only back in idle (busy is high until then). Reset: synchronous, clears
// control state, then sweeps the pair table (busy high); the receiver cannot stall.
`timescale 1ns / 1ps
module dag_longest_path
  import dlp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  edge_req_t           request,
  output logic                result_valid,
  output path_res_t           result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CNT_BITS-1:0] cfg_data
);
  localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_LOAD = 4'd2, S_INIT = 4'd3,
    S_ROOT = 4'd4, S_WALK = 4'd5, S_WEDGE = 4'd6, S_RNODE = 4'd7,
    S_RUPD = 4'd9, S_MAX = 4'd10, S_BACK = 4'd11, S_EMIT = 4'd12, S_LUPD = 4'd13;

  logic [3:0] state;
  logic [CNT_BITS-1:0] node_count;
  logic [PAIR_BITS-1:0] clr_addr;

  // memories
  logic [LINK_BITS-1:0]   pair_slot [PAIRS];
  logic [NODE_BITS-1:0]   edge_target [EDGES];
  logic [LENGTH_BITS-1:0] edge_weight [EDGES];
  logic [LINK_BITS-1:0]   edge_link [EDGES];
  logic [LINK_BITS-1:0]   pair_rd;
  logic [NODE_BITS-1:0]   tgt_rd;
  logic [LENGTH_BITS-1:0] wgt_rd;
  logic [LINK_BITS-1:0]   link_rd;

  // small register files, one entry per node
  logic [LINK_BITS-1:0]   list_head [NODES];
  logic [LINK_BITS-1:0]   list_tail [NODES];
  logic [NODES-1:0]       visited, onpath;
  logic [NODE_BITS-1:0]   stk_node [NODES];
  logic [LINK_BITS-1:0]   stk_cur [NODES];
  logic [NODE_BITS-1:0]   post_order [NODES];
  logic signed [DIST_BITS-1:0] node_dist [NODES];
  logic [NODE_BITS:0]     parent [NODES];
  logic [NODE_BITS-1:0]   pth_from [NODES];
  logic [NODE_BITS-1:0]   pth_to [NODES];
  logic [LENGTH_BITS-1:0] pth_len [NODES];

  logic [LINK_BITS-1:0] edges_loaded;
  edge_req_t req;
  logic [EDGE_BITS-1:0] upd_e;
  logic [CNT_BITS-1:0] n_use;
  logic [CNT_BITS-1:0] root, sp, cnt, k, np;
  logic [NODE_BITS-1:0] cur, node_c;
  logic [LINK_BITS-1:0] e_rd;
  logic [CNT_BITS-1:0] scan;

  assign n_use = (node_count > CNT_BITS'(NODES)) ? CNT_BITS'(NODES) : node_count;
  assign busy = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);

  logic [PAIR_BITS-1:0] pair_addr;
  assign pair_addr = {req.from_node, req.to_node};
  logic in_range;
  assign in_range = ({1'b0, req.from_node} < n_use) && ({1'b0, req.to_node} < n_use);

  logic [EDGE_BITS-1:0] ne;
  assign ne = edges_loaded[EDGE_BITS-1:0];

  // synchronous edge memory read port
  always_ff @(posedge clk) begin
    tgt_rd  <= edge_target[e_rd[EDGE_BITS-1:0]];
    wgt_rd  <= edge_weight[e_rd[EDGE_BITS-1:0]];
    link_rd <= edge_link[e_rd[EDGE_BITS-1:0]];
  end
  always_ff @(posedge clk) begin
    if (state == S_CLEAR) pair_slot[clr_addr] <= NO_LINK;
    else if (state == S_LOAD && in_range && pair_rd == NO_LINK && edges_loaded < LINK_BITS'(EDGES))
      pair_slot[pair_addr] <= edges_loaded;
    pair_rd <= pair_slot[{request.from_node, request.to_node}];
  end

  // relax candidate
  logic signed [DIST_BITS:0] cand;
  logic [NODE_BITS-1:0] cn;
  assign cn = post_order[k[NODE_BITS-1:0] - 1'b1];
  always_comb begin
    cand = (DIST_BITS+1)'(node_dist[node_c]) +
           $signed({{(DIST_BITS+1-LENGTH_BITS){1'b0}}, wgt_rd});
    if (cand > DIST_MAX) cand = DIST_MAX;
  end

  logic [NODE_BITS-1:0] top_node;
  logic [LINK_BITS-1:0] top_cur;
  assign top_node = stk_node[sp[NODE_BITS-1:0] - 1'b1];
  assign top_cur = stk_cur[sp[NODE_BITS-1:0] - 1'b1];
  logic [NODE_BITS-1:0] par;
  assign par = parent[cur][NODE_BITS-1:0];

  always_comb begin
    unique case (state)
      S_LOAD:  e_rd = pair_rd;
      S_WALK:  e_rd = top_cur;
      S_RNODE: e_rd = list_head[cn];
      default: e_rd = link_rd;
    endcase
  end

  always_ff @(posedge clk) begin
    result_valid <= 1'b0;
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      node_count <= CNT_BITS'(NODES);
      edges_loaded <= '0;
      for (int i = 0; i < NODES; i++) begin
        list_head[i] <= NO_LINK;
        list_tail[i] <= NO_LINK;
      end
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == PAIR_BITS'(PAIRS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (cfg_valid) node_count <= cfg_data;
          if (start) begin
            req <= request;
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          state <= req.last_edge ? S_INIT : S_IDLE;
          if (in_range) begin
            if (pair_rd != NO_LINK) begin
              // weight of the stored pair arrives next cycle
              upd_e <= pair_rd[EDGE_BITS-1:0];
              state <= S_LUPD;
            end else if (edges_loaded < LINK_BITS'(EDGES)) begin
              edges_loaded <= edges_loaded + 1'b1;
              edge_target[ne] <= req.to_node;
              edge_weight[ne] <= req.edge_length;
              edge_link[ne] <= NO_LINK;
              if (list_tail[req.from_node] == NO_LINK) list_head[req.from_node] <= edges_loaded;
              else edge_link[list_tail[req.from_node][EDGE_BITS-1:0]] <= edges_loaded;
              list_tail[req.from_node] <= edges_loaded;
            end
          end
        end
        S_LUPD: begin
          if (req.edge_length > wgt_rd) edge_weight[upd_e] <= req.edge_length;
          state <= req.last_edge ? S_INIT : S_IDLE;
        end
        S_INIT: begin
          visited <= '0;
          onpath <= '0;
          for (int i = 0; i < NODES; i++) begin
            node_dist[i] <= '1;
            parent[i] <= '1;
          end
          root <= '0;
          cnt <= '0;
          sp <= '0;
          state <= S_ROOT;
        end
        S_ROOT: begin
          if (root >= n_use) begin
            k <= cnt;
            state <= (cnt == 0) ? S_MAX : S_RNODE;
            scan <= CNT_BITS'(1);
            cur <= '0;
          end else begin
            root <= root + 1'b1;
            if (!visited[root[NODE_BITS-1:0]]) begin
              visited[root[NODE_BITS-1:0]] <= 1'b1;
              stk_node[0] <= root[NODE_BITS-1:0];
              stk_cur[0] <= list_head[root[NODE_BITS-1:0]];
              sp <= CNT_BITS'(1);
              state <= S_WALK;
            end
          end
        end
        S_WALK: begin
          if (sp == 0) state <= S_ROOT;
          else if (top_cur == NO_LINK) begin
            post_order[cnt[NODE_BITS-1:0]] <= top_node;
            cnt <= cnt + 1'b1;
            sp <= sp - 1'b1;
          end else state <= S_WEDGE;
        end
        S_WEDGE: begin
          stk_cur[sp[NODE_BITS-1:0] - 1'b1] <= link_rd;
          if ({1'b0, tgt_rd} < n_use && !visited[tgt_rd] && sp < CNT_BITS'(NODES)) begin
            visited[tgt_rd] <= 1'b1;
            stk_node[sp[NODE_BITS-1:0]] <= tgt_rd;
            stk_cur[sp[NODE_BITS-1:0]] <= list_head[tgt_rd];
            sp <= sp + 1'b1;
          end
          state <= S_WALK;
        end
        S_RNODE: begin
          if (k == 0) state <= S_MAX;
          else begin
            k <= k - 1'b1;
            node_c <= cn;
            state <= (list_head[cn] == NO_LINK) ? S_RNODE : S_RUPD;
          end
        end
        S_RUPD: begin
          if ({1'b0, tgt_rd} < n_use && cand > (DIST_BITS+1)'(node_dist[tgt_rd])) begin
            node_dist[tgt_rd] <= cand[DIST_BITS-1:0];
            parent[tgt_rd] <= {1'b0, node_c};
          end
          state <= (link_rd == NO_LINK) ? S_RNODE : S_RUPD;
        end
        S_MAX: begin
          if (n_use == 0 || scan >= n_use) begin
            np <= '0;
            onpath[cur] <= 1'b1;
            state <= S_BACK;
          end else begin
            if (node_dist[scan[NODE_BITS-1:0]] > node_dist[cur]) cur <= scan[NODE_BITS-1:0];
            scan <= scan + 1'b1;
          end
        end
        S_BACK: begin
          if (n_use == 0 || parent[cur][NODE_BITS] || onpath[par] || np >= CNT_BITS'(NODES)) begin
            k <= np;
            state <= S_EMIT;
          end else begin
            pth_from[np[NODE_BITS-1:0]] <= par;
            pth_to[np[NODE_BITS-1:0]] <= cur;
            pth_len[np[NODE_BITS-1:0]] <= LENGTH_BITS'(node_dist[cur] - node_dist[par]);
            onpath[par] <= 1'b1;
            np <= np + 1'b1;
            cur <= par;
          end
        end
        S_EMIT: begin
          result_valid <= 1'b1;
          if (np == 0) begin
            result <= '{path_from: '0, path_to: '0, path_length: '0,
                        last_in_path: 1'b1, path_empty: 1'b1};
          end else begin
            result <= '{path_from: pth_from[k[NODE_BITS-1:0] - 1'b1],
                        path_to: pth_to[k[NODE_BITS-1:0] - 1'b1],
                        path_length: pth_len[k[NODE_BITS-1:0] - 1'b1],
                        last_in_path: (k == CNT_BITS'(1)), path_empty: 1'b0};
            k <= k - 1'b1;
          end
          if (np == 0 || k == CNT_BITS'(1)) begin
            // drop the graph and sweep the pair table
            edges_loaded <= '0;
            for (int i = 0; i < NODES; i++) begin
              list_head[i] <= NO_LINK;
              list_tail[i] <= NO_LINK;
            end
            clr_addr <= '0;
            state <= S_CLEAR;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: dv/tb_dag_longest_path.sv
// Testbench for dag_longest_path: directed and random edge loads checked against a local predictor.
`timescale 1ns / 1ps
module tb_dag_longest_path;
  import dlp_pkg::*;

  localparam int NONE = -1;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  edge_req_t           request = '0;
  logic                result_valid;
  path_res_t           result;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CNT_BITS-1:0] cfg_data = '0;

  dag_longest_path i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .result_valid(result_valid), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Predictor state: graph as loaded so far and the node count register.
  int unsigned node_reg = 32;
  int pair_edge[PAIRS];
  int edge_to[EDGES];
  int edge_wt[EDGES];
  int edge_next[EDGES];
  int head[NODES];
  int tail[NODES];
  int n_edges;

  path_res_t path_q[$];
  int errors = 0;
  int burst_left = 0;
  int rand_items = 0;

  function automatic int nodes_now();
    return (node_reg > NODES) ? NODES : int'(node_reg);
  endfunction

  function automatic void clear_graph();
    for (int i = 0; i < PAIRS; i++) pair_edge[i] = NONE;
    for (int i = 0; i < NODES; i++) begin
      head[i] = NONE;
      tail[i] = NONE;
    end
    n_edges = 0;
  endfunction

  function automatic void load_edge(int f, int t, int w);
    int n;
    int e;
    n = nodes_now();
    if (f >= n || t >= n) return;
    if (pair_edge[f*NODES+t] != NONE) begin
      e = pair_edge[f*NODES+t];
      if (w > edge_wt[e]) edge_wt[e] = w;
      return;
    end
    if (n_edges >= EDGES) return;
    e = n_edges++;
    edge_to[e] = t;
    edge_wt[e] = w;
    edge_next[e] = NONE;
    if (tail[f] == NONE) head[f] = e;
    else edge_next[tail[f]] = e;
    tail[f] = e;
    pair_edge[f*NODES+t] = e;
  endfunction

  // Post-order walk, relax in reverse order, then trace parents back from the endpoint.
  function automatic void predict_path();
    int n, sp, e, u, c, cur, p, np, cnt;
    bit seen[NODES];
    bit onp[NODES];
    int stk[NODES];
    int cursor[NODES];
    int order[NODES];
    longint best[NODES];
    int par[NODES];
    int pf[NODES];
    int pt[NODES];
    int pl[NODES];
    longint cand;
    path_res_t r;
    n = nodes_now();
    cnt = 0;
    np = 0;
    for (int i = 0; i < NODES; i++) begin
      seen[i] = 0;
      onp[i] = 0;
      best[i] = -1;
      par[i] = NONE;
    end
    for (int root = 0; root < n; root++) begin
      if (!seen[root]) begin
        seen[root] = 1;
        stk[0] = root;
        cursor[0] = head[root];
        sp = 1;
        while (sp > 0) begin
          e = cursor[sp-1];
          if (e == NONE) begin
            if (cnt < NODES) order[cnt++] = stk[sp-1];
            sp--;
          end else begin
            u = edge_to[e];
            cursor[sp-1] = edge_next[e];
            if (u < n && !seen[u] && sp < NODES) begin
              seen[u] = 1;
              stk[sp] = u;
              cursor[sp] = head[u];
              sp++;
            end
          end
        end
      end
    end
    for (int k = cnt; k > 0; k--) begin
      c = order[k-1];
      for (e = head[c]; e != NONE; e = edge_next[e]) begin
        u = edge_to[e];
        if (u < n) begin
          cand = best[c] + longint'(edge_wt[e]);
          if (cand > longint'(DIST_MAX)) cand = longint'(DIST_MAX);
          if (cand > best[u]) begin
            best[u] = cand;
            par[u] = c;
          end
        end
      end
    end
    if (n > 0) begin
      cur = 0;
      for (int i = 1; i < n; i++) if (best[i] > best[cur]) cur = i;
      onp[cur] = 1;
      while (par[cur] != NONE && np < NODES) begin
        p = par[cur];
        if (onp[p]) break;
        pf[np] = p;
        pt[np] = cur;
        pl[np] = int'((best[cur] - best[p]) & 64'hFFFF);
        np++;
        onp[p] = 1;
        cur = p;
      end
    end
    if (np == 0) begin
      r = '0;
      r.last_in_path = 1'b1;
      r.path_empty = 1'b1;
      path_q.push_back(r);
    end
    for (int k = 0; k < np; k++) begin
      r.path_from = NODE_BITS'(pf[np-1-k]);
      r.path_to = NODE_BITS'(pt[np-1-k]);
      r.path_length = LENGTH_BITS'(pl[np-1-k]);
      r.last_in_path = (k + 1 == np);
      r.path_empty = 1'b0;
      path_q.push_back(r);
    end
  endfunction

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // Results are strobed for one cycle; sample mid-cycle.
  always @(negedge clk) begin
    path_res_t want;
    if (!rst && result_valid) begin
      if (path_q.size() == 0) begin
        report("result with no path edge pending");
      end else begin
        want = path_q.pop_front();
        if (result.path_from !== want.path_from)
          report($sformatf("path_from %0d want %0d", result.path_from, want.path_from));
        if (result.path_to !== want.path_to)
          report($sformatf("path_to %0d want %0d", result.path_to, want.path_to));
        if (result.path_length !== want.path_length)
          report($sformatf("path_length %0d want %0d", result.path_length,
                           want.path_length));
        if (result.last_in_path !== want.last_in_path)
          report($sformatf("last_in_path %0b want %0b", result.last_in_path,
                           want.last_in_path));
        if (result.path_empty !== want.path_empty)
          report($sformatf("path_empty %0b want %0b", result.path_empty, want.path_empty));
      end
    end
  end

  // Send one request, idling between bursts.
  task automatic send_edge(input int f, input int t, input int w, input bit last);
    int gap;
    edge_req_t r;
    r.from_node = NODE_BITS'(f);
    r.to_node = NODE_BITS'(t);
    r.edge_length = LENGTH_BITS'(w);
    r.last_edge = last;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    request <= r;
    do @(negedge clk); while (busy);
    @(posedge clk);
    load_edge(f, t, w);
    if (last) begin
      predict_path();
      clear_graph();
    end
  endtask

  // Drain results and let the pair-table sweep finish before touching the register.
  task automatic wait_idle();
    start <= 1'b0;
    while (path_q.size() != 0) @(posedge clk);
    repeat (1300) @(posedge clk);
  endtask

  task automatic write_count(input int v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= CNT_BITS'(v);
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    node_reg = v;
  endtask

  task automatic test_extremes();
    write_count(32);
    send_edge(0, 1, 0, 0);
    send_edge(1, 31, 65535, 0);
    send_edge(0, 31, 1, 0);
    send_edge(0, 1, 5, 0);
    send_edge(0, 1, 3, 0);
    send_edge(31, 31, 65535, 0);
    send_edge(2, 3, 65535, 1);
    send_edge(7, 7, 0, 1);
  endtask

  task automatic test_node_count();
    write_count(0);
    send_edge(0, 1, 100, 1);
    write_count(63);
    send_edge(30, 31, 9, 0);
    send_edge(4, 30, 12, 1);
    write_count(1);
    send_edge(0, 0, 40, 0);
    send_edge(0, 1, 40, 1);
    write_count(2);
    send_edge(0, 5, 70, 0);
    send_edge(1, 0, 2, 1);
  endtask

  task automatic test_cycle();
    write_count(32);
    send_edge(0, 1, 10, 0);
    send_edge(1, 2, 20, 0);
    send_edge(2, 0, 30, 0);
    send_edge(2, 3, 1, 1);
  endtask

  // Fill the edge store, then a repeated pair must still update and a new pair is dropped.
  task automatic test_store_full();
    int sent;
    sent = 0;
    for (int f = 0; f < NODES && sent < 270; f++)
      for (int t = f + 1; t < NODES && sent < 270; t++) begin
        send_edge(f, t, $urandom_range(0, 65535), 0);
        sent++;
      end
    send_edge(0, 1, 65535, 0);
    send_edge(30, 31, 65535, 0);
    send_edge(29, 31, 65535, 1);
  endtask

  task automatic test_random();
    int len, m, a, b, v;
    while (rand_items < 150) begin
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 5))
          0: v = 1;
          1: v = 2;
          2: v = $urandom_range(3, 8);
          3: v = 32;
          4: v = $urandom_range(0, 63);
          default: v = $urandom_range(9, 31);
        endcase
        write_count(v);
      end
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 15);
      m = (nodes_now() == 0) ? NODES : nodes_now();
      for (int i = 0; i < len; i++) begin
        a = $urandom_range(0, m - 1);
        b = $urandom_range(0, m - 1);
        v = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 65535);
        if ($urandom_range(0, 9) == 0)
          send_edge($urandom_range(0, 31), $urandom_range(0, 31), v, i == len - 1);
        else if (a <= b)
          send_edge(a, b, v, i == len - 1);
        else
          send_edge(b, a, v, i == len - 1);
        rand_items++;
      end
    end
  endtask

  initial begin
    clear_graph();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_extremes();
    test_node_count();
    test_cycle();
    test_store_full();
    test_random();
    start <= 1'b0;
    while (path_q.size() != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    if (errors == 0) $display("tb_dag_longest_path: clean");
    else $display("tb_dag_longest_path: errors");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_dag_longest_path: errors");
    $finish;
  end
endmodule
